/* rtl/core/trhc_pkg.sv */
// ----------------------------------------------------------------------------
// Traffic rate history cascade package
// Shared widths, reset values and types for the rate history archive.
// ----------------------------------------------------------------------------
package trhc_pkg;

  localparam int SENT_W   = 64;
  localparam int RECV_W   = 64;
  localparam int TIME_W   = 48;
  localparam int SLOT_O_W = 9;
  localparam int CASC_W   = 2;
  localparam int CFG_W    = 10;

  localparam logic [CFG_W-1:0] CFG_SLOTS_RESET = 10'd360;

  localparam int MAX_SLOTS_DEF  = 512;
  localparam int NUM_LEVELS_DEF = 3;

  // One probe: byte and time counts, also used for running totals.
  typedef struct packed {
    logic [SENT_W-1:0] sent;
    logic [RECV_W-1:0] received;
    logic [TIME_W-1:0] elapsed;
  } sums_t;

  // Sequencer status seen by the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } status_t;

endpackage

/* rtl/core/trhc_if.sv */
// ----------------------------------------------------------------------------
// Traffic rate history cascade channels
// Valid/ready channels for samples, results and the ring size register.
// ----------------------------------------------------------------------------
interface trhc_in_if;
  logic                        valid;
  logic                        ready;
  logic [trhc_pkg::SENT_W-1:0] sent_total;
  logic [trhc_pkg::RECV_W-1:0] received_total;
  logic [trhc_pkg::TIME_W-1:0] now_us;

  modport source (output valid, output sent_total, output received_total,
                  output now_us, input ready);
  modport sink (input valid, input sent_total, input received_total,
                input now_us, output ready);
endinterface

interface trhc_out_if;
  logic                          valid;
  logic                          ready;
  logic [trhc_pkg::SENT_W-1:0]   sent_delta;
  logic [trhc_pkg::RECV_W-1:0]   received_delta;
  logic [trhc_pkg::TIME_W-1:0]   elapsed_us;
  logic [trhc_pkg::SLOT_O_W-1:0] slot_written;
  logic [trhc_pkg::CASC_W-1:0]   levels_cascaded;

  modport source (output valid, output sent_delta, output received_delta,
                  output elapsed_us, output slot_written,
                  output levels_cascaded, input ready);
  modport sink (input valid, input sent_delta, input received_delta,
                input elapsed_us, input slot_written,
                input levels_cascaded, output ready);
endinterface

interface trhc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [trhc_pkg::CFG_W-1:0] slots_per_level;

  modport source (output valid, output slots_per_level, input ready);
  modport sink (input valid, input slots_per_level, output ready);
endinterface

/* rtl/core/traffic_rate_history_cascade_core.sv */
// ----------------------------------------------------------------------------
// Traffic rate history cascade core
// Multi-level round-robin archive of byte and time deltas.
// ----------------------------------------------------------------------------
// Usage: each transfer on in_ch carries a sample of the free-running sent and
// received byte counters and a 48-bit microsecond timestamp. The core returns
// one result per sample on out_ch: the modular deltas since the previous
// sample, the level-0 slot that stored them, and how many levels wrapped and
// passed their totals upward. cfg_ch writes the ring size; it is always ready
// and should be written only while no sample is in flight.
// Processing: after a sample is accepted, the level-state memory walks the
// ring levels it touches in order, from level 0 up to the first level that
// does not wrap or the top level: each level is read, updated and written
// back, and its registered read starts the next level. in_ch is ready
// whenever no sample is being processed, also while a result waits on out_ch.
// Reset clears the previous sample to zero, the ring size to 360 and marks
// every level as fresh (slot 1, zero totals); the probe archive is not
// cleared. When the receiver stalls, the result holds in the output register;
// a following sample is still accepted but waits at its first level, with no
// level written, until that result has been taken.
// ----------------------------------------------------------------------------
module traffic_rate_history_cascade_core #(
  parameter int MAX_SLOTS  = trhc_pkg::MAX_SLOTS_DEF,
  parameter int NUM_LEVELS = trhc_pkg::NUM_LEVELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  trhc_in_if.sink    in_ch,
  trhc_out_if.source out_ch,
  trhc_cfg_if.sink   cfg_ch
);

  logic [trhc_pkg::CFG_W-1:0] slots_r;
  trhc_pkg::status_t          stat;
  trhc_pkg::sums_t            sample;
  trhc_pkg::sums_t            delta;
  logic                       in_xfer;

  // The ring size register takes every write transfer at once.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= trhc_pkg::CFG_SLOTS_RESET;
    end else if (cfg_ch.valid) begin
      slots_r <= cfg_ch.slots_per_level;
    end
  end

  // One sample is in flight at a time.
  assign in_ch.ready = !stat.busy;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign sample.sent     = in_ch.sent_total;
  assign sample.received = in_ch.received_total;
  assign sample.elapsed  = in_ch.now_us;

  trhc_delta u_delta (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (in_xfer),
    .sample (sample),
    .delta  (delta)
  );

  trhc_seq #(
    .MAX_SLOTS  (MAX_SLOTS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_xfer),
    .delta     (delta),
    .slots_cfg (slots_r),
    .status    (stat),
    .out_ch    (out_ch)
  );

  // An accepted sample always starts the level walk.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> stat.busy)
    else $error("sample transfer did not start processing");

  // Finishing the last level hands a result to the output register.
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |=> out_ch.valid && !stat.busy)
    else $error("finished sample produced no result");

  // Cascades can never exceed the number of levels below the top.
  a_casc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> int'(out_ch.levels_cascaded) <= NUM_LEVELS - 1)
    else $error("cascade count beyond level count");

endmodule

/* rtl/core/trhc_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with a registered read.
// ----------------------------------------------------------------------------
module trhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/trhc_delta.sv */
// ----------------------------------------------------------------------------
// Sample delta unit
// Keeps the previous sample and forms modular differences on each transfer.
// ----------------------------------------------------------------------------
module trhc_delta (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  trhc_pkg::sums_t sample,
  output trhc_pkg::sums_t delta
);

  trhc_pkg::sums_t prev_r;
  trhc_pkg::sums_t delta_r;

  // The previous sample starts at zero, so the first delta is the raw sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (take) begin
      prev_r <= sample;
    end
  end

  // Plain wrap-around subtraction at the field widths.
  always_ff @(posedge clk) begin
    if (take) begin
      delta_r.sent     <= sample.sent - prev_r.sent;
      delta_r.received <= sample.received - prev_r.received;
      delta_r.elapsed  <= sample.elapsed - prev_r.elapsed;
    end
  end

  assign delta = delta_r;

endmodule

/* rtl/core/trhc_seq.sv */
// ----------------------------------------------------------------------------
// Level cascade sequencer
// Read-modify-write of per-level ring state, one level per cycle while no
// result waits in the output register, with the probe archive written alongside.
// ----------------------------------------------------------------------------
module trhc_seq #(
  parameter int MAX_SLOTS  = trhc_pkg::MAX_SLOTS_DEF,
  parameter int NUM_LEVELS = trhc_pkg::NUM_LEVELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  trhc_pkg::sums_t            delta,
  input  logic [trhc_pkg::CFG_W-1:0] slots_cfg,
  output trhc_pkg::status_t          status,
  trhc_out_if.source                 out_ch
);

  localparam int SW   = $clog2(MAX_SLOTS);
  localparam int LW   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int SUMW = $bits(trhc_pkg::sums_t);
  localparam int EW   = SW + SUMW;
  localparam int PD   = NUM_LEVELS * MAX_SLOTS;
  localparam int PAW  = $clog2(PD);
  localparam int CW   = (SW + 1 > trhc_pkg::CFG_W) ? SW + 1 : trhc_pkg::CFG_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_PROC = 1'b1;

  logic                          state_r, state_nxt;
  logic [LW-1:0]                 lvl_r;
  logic [trhc_pkg::CASC_W-1:0]   cnt_r;
  trhc_pkg::sums_t               carry_r;
  logic [SW-1:0]                 slot0_r;
  logic [NUM_LEVELS-1:0]         lvl_valid_r;
  logic                          out_valid_r;
  trhc_pkg::sums_t               out_sums_r;
  logic [trhc_pkg::SLOT_O_W-1:0] out_slot_r;
  logic [trhc_pkg::CASC_W-1:0]   out_casc_r;

  logic [CW-1:0]          cfg_ext, ring_size;
  logic [EW-1:0]          lvl_rdata, lvl_wdata;
  logic                   lvl_re;
  logic [LW-1:0]          lvl_raddr;
  logic [SW-1:0]          cur_slot, slot_sel;
  trhc_pkg::sums_t        cur_sum, probe, sum_new;
  logic [SW:0]            nxt_slot;
  logic                   wrap, top, go, cascade, finish;
  logic [PAW-1:0]         probe_addr;
  logic [SW+trhc_pkg::SLOT_O_W-1:0] slot_ext;

  // Effective ring size: the register clamped to [2, MAX_SLOTS].
  always_comb begin
    cfg_ext = CW'(slots_cfg);
    if (cfg_ext < CW'(2)) begin
      ring_size = CW'(2);
    end else if (cfg_ext > CW'(MAX_SLOTS)) begin
      ring_size = CW'(MAX_SLOTS);
    end else begin
      ring_size = cfg_ext;
    end
  end

  // A level never written yet reads as its reset state: slot 1, zero totals.
  always_comb begin
    if (lvl_valid_r[lvl_r]) begin
      cur_slot = lvl_rdata[EW-1 -: SW];
      cur_sum  = trhc_pkg::sums_t'(lvl_rdata[SUMW-1:0]);
    end else begin
      cur_slot = SW'(1);
      cur_sum  = '0;
    end
  end

  assign probe = (lvl_r == '0) ? delta : carry_r;

  always_comb begin
    sum_new.sent     = cur_sum.sent + probe.sent;
    sum_new.received = cur_sum.received + probe.received;
    sum_new.elapsed  = cur_sum.elapsed + probe.elapsed;
  end

  assign nxt_slot = {1'b0, cur_slot} + (SW+1)'(1);
  assign wrap     = CW'(nxt_slot) >= ring_size;
  assign top      = (lvl_r == LW'(NUM_LEVELS - 1));
  assign go       = (state_r == ST_PROC) && (!out_valid_r || out_ch.ready);
  assign cascade  = wrap && !top;
  assign finish   = go && !cascade;

  // A cascading level hands its new totals upward and is cleared.
  assign lvl_wdata = cascade ? {SW'(0), SUMW'(0)}
                             : {(wrap ? SW'(0) : nxt_slot[SW-1:0]), sum_new};
  assign lvl_re    = start || (go && cascade);
  assign lvl_raddr = start ? '0 : lvl_r + LW'(1);

  assign probe_addr = PAW'(lvl_r) * PAW'(MAX_SLOTS) + PAW'(cur_slot);

  assign slot_sel = (lvl_r == '0) ? cur_slot : slot0_r;
  assign slot_ext = (SW + trhc_pkg::SLOT_O_W)'(slot_sel);

  trhc_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_LEVELS)
  ) u_level_ram (
    .clk   (clk),
    .we    (go),
    .waddr (lvl_r),
    .wdata (lvl_wdata),
    .re    (lvl_re),
    .raddr (lvl_raddr),
    .rdata (lvl_rdata)
  );

  trhc_ram #(
    .WIDTH (SUMW),
    .DEPTH (PD)
  ) u_probe_ram (
    .clk   (clk),
    .we    (go),
    .waddr (probe_addr),
    .wdata (probe),
    .re    (1'b0),
    .raddr ('0),
    .rdata ()
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_PROC;
        end
      end
      ST_PROC: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lvl_r       <= '0;
      cnt_r       <= '0;
      lvl_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (start) begin
        lvl_r <= '0;
        cnt_r <= '0;
      end
      if (go) begin
        lvl_valid_r[lvl_r] <= 1'b1;
        if (cascade) begin
          lvl_r <= lvl_r + LW'(1);
          cnt_r <= cnt_r + trhc_pkg::CASC_W'(1);
        end else begin
          out_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      if (lvl_r == '0) begin
        slot0_r <= cur_slot;
      end
      if (cascade) begin
        carry_r <= sum_new;
      end else begin
        out_sums_r <= delta;
        out_slot_r <= slot_ext[trhc_pkg::SLOT_O_W-1:0];
        out_casc_r <= cnt_r;
      end
    end
  end

  assign status.busy = (state_r == ST_PROC);
  assign status.done = finish;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.sent_delta      = out_sums_r.sent;
  assign out_ch.received_delta  = out_sums_r.received;
  assign out_ch.elapsed_us      = out_sums_r.elapsed;
  assign out_ch.slot_written    = out_slot_r;
  assign out_ch.levels_cascaded = out_casc_r;

endmodule
